@@ rtl/sqoe_pkg.sv @@
// Shared types and constants for the stack/queue opcode engine.
package sqoe_pkg;

    // Width of one stored entry and of the value fields
    localparam int unsigned DATA_W = 32;

    // Opcodes carried by an input transaction
    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_PALL = 3'd1,
        OP_PINT = 3'd2,
        OP_POP  = 3'd3,
        OP_ADD  = 3'd4
    } t_op;

    // Status codes carried by a result transaction
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_BADARG = 3'd1,
        ST_PINT   = 3'd2,
        ST_POP    = 3'd3,
        ST_ADD    = 3'd4,
        ST_FULL   = 3'd5,
        ST_HALT   = 3'd6
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PINT,
        S_PALL,
        S_ADD0,
        S_ADD1
    } t_state;

    // Which store slot the read port addresses
    typedef enum logic [1:0] {
        RD_TOP,
        RD_SECOND,
        RD_NEXT
    } t_rd_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic    push_top;    // push above the top entry
        logic    push_bottom; // append below the bottom entry
        logic    pop;         // drop the top entry
        logic    add_wr;      // write sum over second entry, drop top
        logic    rd_en;       // issue a store read
        t_rd_sel rd_sel;
        logic    cnt_clr;     // restart the readout counter
        logic    cnt_inc;     // advance the readout counter
        logic    latch_a;     // hold the first add operand
        logic    out_load;    // load the result register
        t_status out_status;
        logic    out_ram;     // result carries the read entry
        logic    out_pall;    // last flag follows the readout counter
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;     // no live entries
        logic short_cnt; // fewer than two live entries
        logic full;      // every slot live
        logic pall_last; // readout counter is on the bottom entry
        logic out_free;  // result register can take a new result
    } t_dp_stat;

endpackage

@@ rtl/sqoe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sqoe_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/sqoe_ctrl.sv @@
// Controller: opcode decode, error checks, halt flag and sequencing FSM.
module sqoe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_mode,
    input  logic              i_arg_ok,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  sqoe_pkg::t_dp_stat i_stat,
    output sqoe_pkg::t_dp_cmd  o_cmd
);

    sqoe_pkg::t_state r_state, n_state;
    logic             r_halted, n_halted;
    logic             r_queue_mode;
    logic             accept;

    // Input is taken only in idle with room in the result register
    assign accept  = (r_state == sqoe_pkg::S_IDLE) && i_stat.out_free && i_valid;
    assign o_stall = !((r_state == sqoe_pkg::S_IDLE) && i_stat.out_free);

    // State, halt flag and mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sqoe_pkg::S_IDLE;
            r_halted     <= 1'b0;
            r_queue_mode <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_halted <= n_halted;
            if (i_cfg_wr_en) begin
                r_queue_mode <= i_cfg_wr_data;
            end
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_halted = r_halted;
        o_cmd    = '0;
        o_cmd.out_status = sqoe_pkg::ST_OK;
        o_cmd.rd_sel     = sqoe_pkg::RD_TOP;

        unique case (r_state)
            sqoe_pkg::S_IDLE: begin
                if (accept) begin
                    o_cmd.out_load = 1'b1;
                    if (r_halted) begin
                        o_cmd.out_status = sqoe_pkg::ST_HALT;
                    end else begin
                        unique case (sqoe_pkg::t_op'(i_mode))
                            sqoe_pkg::OP_PUSH: begin
                                if (!i_arg_ok) begin
                                    o_cmd.out_status = sqoe_pkg::ST_BADARG;
                                    n_halted         = 1'b1;
                                end else if (i_stat.full) begin
                                    o_cmd.out_status = sqoe_pkg::ST_FULL;
                                    n_halted         = 1'b1;
                                end else begin
                                    o_cmd.push_bottom = r_queue_mode;
                                    o_cmd.push_top    = !r_queue_mode;
                                end
                            end
                            sqoe_pkg::OP_PALL: begin
                                // empty store answers at once with no value
                                if (!i_stat.empty) begin
                                    o_cmd.out_load = 1'b0;
                                    o_cmd.rd_en    = 1'b1;
                                    o_cmd.rd_sel   = sqoe_pkg::RD_TOP;
                                    o_cmd.cnt_clr  = 1'b1;
                                    n_state        = sqoe_pkg::S_PALL;
                                end
                            end
                            sqoe_pkg::OP_PINT: begin
                                if (i_stat.empty) begin
                                    o_cmd.out_status = sqoe_pkg::ST_PINT;
                                    n_halted         = 1'b1;
                                end else begin
                                    o_cmd.out_load = 1'b0;
                                    o_cmd.rd_en    = 1'b1;
                                    o_cmd.rd_sel   = sqoe_pkg::RD_TOP;
                                    n_state        = sqoe_pkg::S_PINT;
                                end
                            end
                            sqoe_pkg::OP_POP: begin
                                if (i_stat.empty) begin
                                    o_cmd.out_status = sqoe_pkg::ST_POP;
                                    n_halted         = 1'b1;
                                end else begin
                                    o_cmd.pop = 1'b1;
                                end
                            end
                            sqoe_pkg::OP_ADD: begin
                                if (i_stat.short_cnt) begin
                                    o_cmd.out_status = sqoe_pkg::ST_ADD;
                                    n_halted         = 1'b1;
                                end else begin
                                    o_cmd.out_load = 1'b0;
                                    o_cmd.rd_en    = 1'b1;
                                    o_cmd.rd_sel   = sqoe_pkg::RD_TOP;
                                    n_state        = sqoe_pkg::S_ADD0;
                                end
                            end
                            default: begin
                                // unused opcode: plain OK result
                            end
                        endcase
                    end
                end
            end
            sqoe_pkg::S_PINT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_ram  = 1'b1;
                    n_state        = sqoe_pkg::S_IDLE;
                end
            end
            sqoe_pkg::S_PALL: begin
                // one entry per free result slot, top down
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_ram  = 1'b1;
                    o_cmd.out_pall = 1'b1;
                    if (i_stat.pall_last) begin
                        n_state = sqoe_pkg::S_IDLE;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_sel  = sqoe_pkg::RD_NEXT;
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            sqoe_pkg::S_ADD0: begin
                o_cmd.latch_a = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = sqoe_pkg::RD_SECOND;
                n_state       = sqoe_pkg::S_ADD1;
            end
            sqoe_pkg::S_ADD1: begin
                if (i_stat.out_free) begin
                    o_cmd.add_wr   = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = sqoe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sqoe_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/sqoe_dp.sv @@
// Datapath: circular store, pointers, readout counter and result register.
module sqoe_dp #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sqoe_pkg::t_dp_cmd             i_cmd,
    input  logic signed [sqoe_pkg::DATA_W-1:0] i_push_value,
    output sqoe_pkg::t_dp_stat            o_stat,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_status,
    output logic signed [sqoe_pkg::DATA_W-1:0] o_value,
    output logic                          o_has_value,
    output logic                          o_last
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW:0] DEPTH_W = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);

    logic [PW-1:0] r_top, n_top;
    logic [CW-1:0] r_fill, n_fill;
    logic [PW-1:0] r_cnt, n_cnt;
    logic [sqoe_pkg::DATA_W-1:0] r_a;

    logic                        r_out_valid, n_out_valid;
    sqoe_pkg::t_status           r_out_status;
    logic [sqoe_pkg::DATA_W-1:0] r_out_value;
    logic                        r_out_has;
    logic                        r_out_last;

    logic [PW:0]   sum_second, sum_fill, sum_next;
    logic [PW-1:0] slot_second, slot_fill, slot_next, slot_above;
    logic [PW-1:0] cnt_plus;
    logic [CW-1:0] cnt_plus_w;

    logic                        wr_en;
    logic [PW-1:0]               wr_addr;
    logic [sqoe_pkg::DATA_W-1:0] wr_data;
    logic [PW-1:0]               rd_addr;
    logic [sqoe_pkg::DATA_W-1:0] rd_data;
    logic                        out_free;

    // Slot arithmetic modulo the store depth
    assign cnt_plus    = r_cnt + PW'(1);
    assign sum_second  = {1'b0, r_top} + (PW + 1)'(1);
    assign sum_fill    = {1'b0, r_top} + (PW + 1)'(r_fill);
    assign sum_next    = {1'b0, r_top} + {1'b0, cnt_plus};
    assign slot_second = (sum_second >= DEPTH_W) ? PW'(sum_second - DEPTH_W)
                                                 : sum_second[PW-1:0];
    assign slot_fill   = (sum_fill >= DEPTH_W) ? PW'(sum_fill - DEPTH_W)
                                               : sum_fill[PW-1:0];
    assign slot_next   = (sum_next >= DEPTH_W) ? PW'(sum_next - DEPTH_W)
                                               : sum_next[PW-1:0];
    assign slot_above  = (r_top == '0) ? PTR_MAX : r_top - PW'(1);

    // Status towards the controller
    assign cnt_plus_w = CW'(r_cnt) + CW'(1);
    assign out_free   = !r_out_valid || !i_stall;
    always_comb begin
        o_stat           = '0;
        o_stat.empty     = (r_fill == '0);
        o_stat.short_cnt = (r_fill < CW'(2));
        o_stat.full      = (r_fill >= CW'(DEPTH));
        o_stat.pall_last = (cnt_plus_w == r_fill);
        o_stat.out_free  = out_free;
    end

    // Store write and read address selection
    always_comb begin
        wr_en   = i_cmd.push_top || i_cmd.push_bottom || i_cmd.add_wr;
        wr_addr = r_top;
        wr_data = i_push_value;
        priority if (i_cmd.push_top) begin
            wr_addr = slot_above;
        end else if (i_cmd.push_bottom) begin
            wr_addr = slot_fill;
        end else if (i_cmd.add_wr) begin
            wr_addr = slot_second;
            wr_data = r_a + rd_data;
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            sqoe_pkg::RD_TOP:    rd_addr = r_top;
            sqoe_pkg::RD_SECOND: rd_addr = slot_second;
            sqoe_pkg::RD_NEXT:   rd_addr = slot_next;
            default:             rd_addr = r_top;
        endcase
    end

    sqoe_ram #(
        .WIDTH (sqoe_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Pointer, fill and counter updates
    always_comb begin
        n_top  = r_top;
        n_fill = r_fill;
        n_cnt  = r_cnt;
        if (i_cmd.push_top) begin
            n_top  = slot_above;
            n_fill = r_fill + CW'(1);
        end
        if (i_cmd.push_bottom) begin
            n_fill = r_fill + CW'(1);
        end
        if (i_cmd.pop || i_cmd.add_wr) begin
            n_top  = slot_second;
            n_fill = r_fill - CW'(1);
        end
        if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt = cnt_plus;
        end
        n_out_valid = r_out_valid && i_stall;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_top       <= n_top;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Add operand and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_a) begin
            r_a <= rd_data;
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_value  <= i_cmd.out_ram ? rd_data : '0;
            r_out_has    <= i_cmd.out_ram;
            r_out_last   <= i_cmd.out_pall ? o_stat.pall_last : 1'b1;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value     = r_out_value;
    assign o_has_value = r_out_has;
    assign o_last      = r_out_last;

endmodule

@@ rtl/stack_queue_opcode_engine_core.sv @@
// Top level of the stack/queue opcode engine: controller plus datapath.
//
// Input channel: i_valid / o_stall with i_mode, i_push_value, i_arg_ok; a
// transaction is taken on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_status, o_value, o_has_value and
// o_last; o_last marks the final result of one input transaction.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into queue_mode (0 stack,
// 1 queue); write only while no transaction is in flight.
// Push, pop, pall on an empty store, failing opcodes and unused opcodes load
// their result into the output register when they are accepted, and a new
// transaction can be taken every cycle while the output is not stalled. pint
// and add wait on the registered read port of the entry RAM (add reads two
// entries one after the other). pall reads one entry per cycle through the
// same port while the output is not stalled.
// The input is stalled whenever the output register holds a result that
// the receiver is stalling, so results are never dropped or overwritten.
// Reset (synchronous, active low) empties the store, clears the halt flag
// and selects stack mode; entry contents are not cleared and are never read
// before being written. Any error halts the block until the next reset.
module stack_queue_opcode_engine_core #(
    parameter int unsigned DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_push_value,
    input  logic               i_arg_ok,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_value,
    output logic               o_has_value,
    output logic               o_last
);

    sqoe_pkg::t_dp_cmd  cmd;
    sqoe_pkg::t_dp_stat stat;

    // Sequencing and error handling
    sqoe_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_arg_ok      (i_arg_ok),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    // Store and result path
    sqoe_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_push_value (i_push_value),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_value      (o_value),
        .o_has_value  (o_has_value),
        .o_last       (o_last)
    );

endmodule

@@ tb/stack_queue_opcode_engine_core_tb.sv @@
// Self-checking testbench for the stack/queue opcode engine core.
module stack_queue_opcode_engine_core_tb;
    import sqoe_pkg::*;

    localparam int unsigned STORE_DEPTH   = 64;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PRINT_CAP     = 40;
    localparam logic [2:0]  OP_UNUSED_MIN = 3'd5;
    localparam logic [2:0]  OP_UNUSED_MAX = 3'd7;

    // Error provoked in the closing phase, one per run
    typedef enum int unsigned {
        FAULT_BADARG,
        FAULT_PINT_EMPTY,
        FAULT_POP_EMPTY,
        FAULT_ADD_SHORT,
        FAULT_FULL
    } t_fault;

    // One result transaction
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic        has_value;
        logic        last;
    } t_result;

    // Shadow of the engine plus queue of results it should produce
    class engine_scoreboard;
        logic [31:0] store [STORE_DEPTH];
        int unsigned top;
        int unsigned fill;
        bit          halted;
        bit          queue_mode;
        t_result     pending_results [$];
        int unsigned mismatches;

        function void set_queue_mode(bit m);
            queue_mode = m;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void expect_result(logic [2:0] st, logic [31:0] val, logic has,
                                    logic lst);
            t_result r;
            r.status    = st;
            r.value     = val;
            r.has_value = has;
            r.last      = lst;
            pending_results.push_back(r);
        endfunction

        function void raise_fault(logic [2:0] st);
            halted = 1'b1;
            expect_result(st, '0, 1'b0, 1'b1);
        endfunction

        // Work out the results of one accepted input transaction
        function void predict_opcode(logic [2:0] op, logic [31:0] arg, logic ok);
            int unsigned i;
            logic [31:0] total;
            if (halted) begin
                expect_result(ST_HALT, '0, 1'b0, 1'b1);
                return;
            end
            case (op)
                OP_PUSH: begin
                    if (!ok) begin
                        raise_fault(ST_BADARG);
                        return;
                    end
                    if (fill >= STORE_DEPTH) begin
                        raise_fault(ST_FULL);
                        return;
                    end
                    if (queue_mode) begin
                        store[(top + fill) % STORE_DEPTH] = arg;
                    end else begin
                        top = (top + STORE_DEPTH - 1) % STORE_DEPTH;
                        store[top] = arg;
                    end
                    fill++;
                end
                OP_PALL: begin
                    if (fill != 0) begin
                        for (i = 0; i < fill; i++)
                            expect_result(ST_OK, store[(top + i) % STORE_DEPTH], 1'b1,
                                          i + 1 == fill);
                        return;
                    end
                end
                OP_PINT: begin
                    if (fill == 0) begin
                        raise_fault(ST_PINT);
                        return;
                    end
                    expect_result(ST_OK, store[top], 1'b1, 1'b1);
                    return;
                end
                OP_POP: begin
                    if (fill == 0) begin
                        raise_fault(ST_POP);
                        return;
                    end
                    top = (top + 1) % STORE_DEPTH;
                    fill--;
                end
                OP_ADD: begin
                    if (fill < 2) begin
                        raise_fault(ST_ADD);
                        return;
                    end
                    total = store[top] + store[(top + 1) % STORE_DEPTH];
                    top = (top + 1) % STORE_DEPTH;
                    store[top] = total;
                    fill--;
                end
                default: ;
            endcase
            expect_result(ST_OK, '0, 1'b0, 1'b1);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("mismatch: %s", msg);
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(logic [2:0] st, logic [31:0] val, logic has, logic lst);
            t_result want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d value=%h",
                                          st, val));
                return;
            end
            want = pending_results.pop_front();
            if (st !== want.status)
                report_mismatch($sformatf("status %0d, wanted %0d", st, want.status));
            if (val !== want.value)
                report_mismatch($sformatf("value %h, wanted %h", val, want.value));
            if (has !== want.has_value)
                report_mismatch($sformatf("has_value %b, wanted %b", has,
                                          want.has_value));
            if (lst !== want.last)
                report_mismatch($sformatf("last %b, wanted %b", lst, want.last));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_stall;
    logic [2:0]         i_mode        = '0;
    logic signed [31:0] i_push_value  = '0;
    logic               i_arg_ok      = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic               i_cfg_wr_data = 1'b0;
    logic               o_valid;
    logic               i_stall       = 1'b0;
    logic [2:0]         o_status;
    logic signed [31:0] o_value;
    logic               o_has_value;
    logic               o_last;

    engine_scoreboard sb = new();

    int unsigned burst_left = 0;
    bit          gaps_on    = 1'b1;

    stack_queue_opcode_engine_core #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .i_arg_ok     (i_arg_ok),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_value      (o_value),
        .o_has_value  (o_has_value),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Push values lean towards the wrap-around corners
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one input transaction and hold it until it is taken
    task automatic drive_item(logic [2:0] op, logic [31:0] val, logic ok);
        if (burst_left == 0) begin
            if (gaps_on) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_mode       <= op;
        i_push_value <= val;
        i_arg_ok     <= ok;
        do @(posedge i_clk); while (o_stall);
        sb.predict_opcode(op, val, ok);
    endtask

    // Hold the sender until every expected result is back, then let it settle
    task automatic wait_for_results();
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_queue_mode(bit m);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_queue_mode(m);
    endtask

    // Legal opcode steering the fill level towards a target; no errors
    task automatic drive_random(int unsigned target);
        logic [2:0]  op;
        logic [31:0] val;
        logic        ok;
        int unsigned r;
        r   = $urandom_range(0, 99);
        val = pick_value();
        ok  = 1'($urandom_range(0, 1));
        if (r < 10) begin
            op = OP_PALL;
        end else if (r < 20 && sb.fill != 0) begin
            op = OP_PINT;
        end else if (r < 26) begin
            op = 3'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
        end else if (sb.fill < target) begin
            op = OP_PUSH;
            ok = 1'b1;
        end else if (sb.fill > target) begin
            op = (sb.fill >= 2 && r[0]) ? OP_ADD : OP_POP;
        end else if (sb.fill != 0) begin
            op = OP_PINT;
        end else begin
            op = OP_PUSH;
            ok = 1'b1;
        end
        drive_item(op, val, ok);
    endtask

    // Provoke one error, then show the halted behaviour
    task automatic drive_fault();
        t_fault      kind;
        int unsigned keep;
        kind = t_fault'($urandom_range(FAULT_BADARG, FAULT_FULL));
        keep = $urandom_range(0, 1);
        case (kind)
            FAULT_BADARG: begin
                drive_item(OP_PUSH, pick_value(), 1'b0);
            end
            FAULT_PINT_EMPTY, FAULT_POP_EMPTY: begin
                while (sb.fill != 0)
                    drive_item(OP_POP, pick_value(), 1'($urandom_range(0, 1)));
                drive_item(kind == FAULT_POP_EMPTY ? OP_POP : OP_PINT, pick_value(),
                           1'($urandom_range(0, 1)));
            end
            FAULT_ADD_SHORT: begin
                while (sb.fill > keep) drive_item(OP_POP, pick_value(), 1'b1);
                while (sb.fill < keep) drive_item(OP_PUSH, pick_value(), 1'b1);
                drive_item(OP_ADD, pick_value(), 1'($urandom_range(0, 1)));
            end
            default: begin
                while (sb.fill < STORE_DEPTH) drive_item(OP_PUSH, pick_value(), 1'b1);
                drive_item(OP_PUSH, pick_value(), 1'b1);
            end
        endcase
        repeat (4)
            drive_item(3'($urandom_range(0, 7)), pick_value(), 1'($urandom_range(0, 1)));
    endtask

    // Receiver: check accepted results and stall on a changing pattern
    initial begin : result_monitor
        int unsigned style;
        int unsigned run;
        int unsigned tick;
        bit          hold;
        style = 0;
        run   = 0;
        tick  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                sb.check_result(o_status, o_value, o_has_value, o_last);
            tick++;
            if (tick % 48 == 0) style = $urandom_range(0, 3);
            case (style)
                0:       hold = 1'b0;
                1:       hold = ($urandom_range(0, 2) == 0);
                2:       hold = ($urandom_range(0, 2) != 0);
                default: hold = tick[0];
            endcase
            // keep stall runs short
            if (run >= 3) hold = 1'b0;
            run = hold ? run + 1 : 0;
            i_stall <= hold;
        end
    end

    // Main sequence: directed opcodes, random phases, closing error
    initial begin : stimulus
        int unsigned ph;
        int unsigned k;
        int unsigned n;
        int unsigned target;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty pall, unused opcodes, wrapping adds in stack mode
        drive_item(OP_PALL, $urandom, 1'b1);
        drive_item(3'(OP_UNUSED_MIN), $urandom, 1'b0);
        drive_item(3'(OP_UNUSED_MIN + 1), $urandom, 1'b1);
        drive_item(OP_UNUSED_MAX, $urandom, 1'b0);
        drive_item(OP_PUSH, 32'h7FFF_FFFF, 1'b1);
        drive_item(OP_PUSH, 32'h8000_0000, 1'b1);
        drive_item(OP_PINT, $urandom, 1'b0);
        drive_item(OP_PALL, $urandom, 1'b0);
        drive_item(OP_ADD, $urandom, 1'b1);
        drive_item(OP_PUSH, 32'h0000_0001, 1'b1);
        drive_item(OP_ADD, $urandom, 1'b0);
        drive_item(OP_PINT, $urandom, 1'b1);
        drive_item(OP_POP, $urandom, 1'b0);
        drive_item(OP_PALL, $urandom, 1'b1);

        // same ground in queue mode
        write_queue_mode(1'b1);
        drive_item(OP_PUSH, 32'h0000_0001, 1'b1);
        drive_item(OP_PUSH, 32'h0000_0002, 1'b1);
        drive_item(OP_PUSH, 32'hFFFF_FFFF, 1'b1);
        drive_item(OP_PALL, $urandom, 1'b0);
        drive_item(OP_PINT, $urandom, 1'b1);
        drive_item(OP_ADD, $urandom, 1'b0);
        drive_item(OP_POP, $urandom, 1'b1);
        drive_item(OP_PALL, $urandom, 1'b0);
        drive_item(OP_POP, $urandom, 1'b1);

        // random phases; phase 3 fills the store to the brim
        for (ph = 0; ph < 6; ph++) begin
            write_queue_mode(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
            gaps_on = (ph % 3 != 2);
            n = (ph == 3) ? 100 : 36;
            target = 8;
            for (k = 0; k < n; k++) begin
                if (ph == 3)
                    target = STORE_DEPTH;
                else if (k % 20 == 0)
                    target = ($urandom_range(0, 3) == 0) ? $urandom_range(0, STORE_DEPTH)
                                                        : $urandom_range(0, 24);
                if (ph == 4 && k == n / 2) wait_for_results();
                drive_random(target);
            end
        end

        write_queue_mode(1'($urandom_range(0, 1)));
        drive_fault();

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
